// ----- rtl/core/bgi_pkg.sv -----
// ----------------------------------------------------------------------------
// bgi_pkg: shared definitions for the bilinear grid interpolator
// Breakpoint grids, constant reciprocals, datapath widths, opcodes and the
// command word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package bgi_pkg;

  // Grid size and storage.
  localparam int MASS_POINTS  = 13;
  localparam int METAL_POINTS = 5;
  localparam int MASS_MAX     = 16;
  localparam int METAL_MAX    = 8;
  localparam int TBL_DEPTH    = METAL_POINTS * MASS_POINTS;
  localparam int TBL_AW       = $clog2(TBL_DEPTH);

  // Field widths of the channels.
  localparam int COORD_W = 16;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int VALUE_W = 32;

  // Datapath widths.
  localparam int RECIP_W    = 25;              // largest reciprocal is below 2^25
  localparam int MUL_W      = 26;              // shared signed multiplier operand
  localparam int PROD_W     = 2 * MUL_W;
  localparam int FRAC_LSB   = 16;              // fractions are Q16
  localparam int FZ_W       = 22;              // metallicity fraction incl. extrapolation
  localparam int FM_W       = 20;              // mass fraction incl. extrapolation
  localparam int SPLIT      = 20;              // difference is multiplied in two parts
  localparam int DIFF_W     = 42;
  localparam int T_W        = 40;              // column values after the first blend
  localparam int ACC_W      = 64;
  localparam int RES_W      = ACC_W - FRAC_LSB;
  localparam int ROUND_HALF = 1 << (FRAC_LSB - 1);

  // Edges from the one that accepts a query beat to the first one at which
  // its result beat can be taken.
  localparam int RESULT_DELAY = 20;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // Breakpoints: mass in Q4.12, metallicity in Q0.16. Unused slots are zero.
  localparam coord_t MASS_BP [MASS_MAX] = '{
    16'd3686, 16'd4096, 16'd5325, 16'd5325, 16'd6144, 16'd6963, 16'd8192,
    16'd10240, 16'd12288, 16'd16384, 16'd20480, 16'd28672, 16'd32768,
    16'd0, 16'd0, 16'd0};
  localparam coord_t METAL_BP [METAL_MAX] = '{
    16'd66, 16'd262, 16'd524, 16'd1311, 16'd2621, 16'd0, 16'd0, 16'd0};

  // round(2^32 / width) of the interval below each breakpoint; zero where the
  // interval is empty or there is no interval.
  localparam recip_t MASS_RECIP [MASS_MAX] = '{
    25'd0, 25'd10475530, 25'd3494685, 25'd0, 25'd5244160, 25'd5244160,
    25'd3494685, 25'd2097152, 25'd2097152, 25'd1048576, 25'd1048576,
    25'd524288, 25'd1048576, 25'd0, 25'd0, 25'd0};
  localparam recip_t METAL_RECIP [METAL_MAX] = '{
    25'd0, 25'd21913098, 25'd16393005, 25'd5457392, 25'd3278601,
    25'd0, 25'd0, 25'd0};

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Which of the three blends is running.
  typedef enum logic [1:0] {
    BLEND_COL0 = 2'd0,
    BLEND_COL1 = 2'd1,
    BLEND_MASS = 2'd2
  } blend_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_FRAC_Z = 2'd0,
    MUL_FRAC_M = 2'd1,
    MUL_LO     = 2'd2,
    MUL_HI     = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     tbl_wr;
    logic     cap_query;
    logic     load_index;
    logic     rd_en;
    logic     rd_col;
    logic     lat_col0;
    logic     lat_col1;
    logic     cap_fz;
    logic     cap_fm;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_diff;
    logic     acc_init;
    logic     acc_add;
    logic     fin_en;
    blend_t   blend_sel;
    logic     out_load;
  } cmd_t;

  // Row-major table address.
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    return TBL_AW'(row) * TBL_AW'(MASS_POINTS) + TBL_AW'(col);
  endfunction

endpackage

// ----- rtl/core/bgi_if.sv -----
// ----------------------------------------------------------------------------
// bgi_if: channel interfaces of the bilinear grid interpolator
// Request channel (table writes and queries) and result channel, each with
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface bgi_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [bgi_pkg::COORD_W-1:0]    star_mass;
  logic [bgi_pkg::COORD_W-1:0]    metallicity;
  logic [bgi_pkg::ROW_W-1:0]      row_index;
  logic [bgi_pkg::COL_W-1:0]      column_index;
  logic signed [bgi_pkg::VALUE_W-1:0] entry_value;

  modport source (
    output valid, opcode, star_mass, metallicity, row_index, column_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, star_mass, metallicity, row_index, column_index, entry_value,
    output ready
  );
endinterface

interface bgi_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [bgi_pkg::VALUE_W-1:0] interpolated_value;
  logic                               saturated;

  modport source (
    output valid, interpolated_value, saturated,
    input  ready
  );
  modport sink (
    input  valid, interpolated_value, saturated,
    output ready
  );
endinterface

// ----- rtl/core/bilinear_grid_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator_top: table-driven bilinear yield interpolator
// Holds a metallicity-by-mass table of signed yields and answers queries with
// a value interpolated between fixed, non-uniform breakpoints.
// ----------------------------------------------------------------------------
// Usage. The request channel carries two kinds of beat. A write beat
// (opcode 0) stores entry_value at row_index, column_index; a beat that
// addresses a row or column outside the grid is dropped. A write beat is
// taken while idle and gives no result. A query beat (opcode 1) carries a
// Q4.12 mass and a Q0.16 metallicity and gives exactly one result beat with
// the interpolated value and a flag that tells whether it was clipped.
//
// Sequencing. A query holds the block until its result is loaded: result
// valid rises as the output step ends, and the next request beat can be
// taken once the sequencer is idle again. The steps use the single shared
// 26x26 multiplier: two fraction products, then three blends of two
// partial products each, every blend walking difference, two multiplies,
// accumulate and round. Write beats stream at one per cycle while idle.
//
// Reset clears the sequencer and the result valid; the table keeps whatever
// it held, and an entry must be written before a query reads it. When the
// receiver stalls, the finished result waits in the output register while
// new beats are still taken; a following query finishes its arithmetic and
// then waits in its last step until the output register is free.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator_top (
  input  logic      clk,
  input  logic      rst,
  bgi_req_if.sink   req,
  bgi_rsp_if.source rsp
);

  bgi_pkg::cmd_t cmd;

  // Sequencer: owns the request ready, the result valid and all steps.
  bgi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd)
  );

  // Datapath: table, multiplier, accumulator and result payload register.
  bgi_datapath u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .star_mass          (req.star_mass),
    .metallicity        (req.metallicity),
    .row_index          (req.row_index),
    .column_index       (req.column_index),
    .entry_value        (req.entry_value),
    .interpolated_value (rsp.interpolated_value),
    .saturated          (rsp.saturated)
  );

endmodule

// ----- rtl/core/bgi_ctrl.sv -----
// ----------------------------------------------------------------------------
// bgi_ctrl: sequencer of the bilinear grid interpolator
// One-hot state machine that steps a query through index search, fraction
// multiplies and three two-part blends, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bgi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output bgi_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_INDEX  = 10'b00_0000_0010,
    ST_FRAC_Z = 10'b00_0000_0100,
    ST_FRAC_M = 10'b00_0000_1000,
    ST_DIFF   = 10'b00_0001_0000,
    ST_MUL_LO = 10'b00_0010_0000,
    ST_MUL_HI = 10'b00_0100_0000,
    ST_ACCUM  = 10'b00_1000_0000,
    ST_FINISH = 10'b01_0000_0000,
    ST_OUTPUT = 10'b10_0000_0000
  } state_t;

  state_t          state, state_next;
  bgi_pkg::blend_t blend, blend_next;
  logic            out_valid_next;
  logic            accept;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.blend_sel = blend;
    state_next    = state;
    blend_next    = blend;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == bgi_pkg::OP_QUERY) begin
            cmd.cap_query = 1'b1;
            state_next    = ST_INDEX;
          end else begin
            cmd.tbl_wr = 1'b1;
          end
        end
      end
      ST_INDEX: begin
        cmd.load_index = 1'b1;
        blend_next     = bgi_pkg::BLEND_COL0;
        state_next     = ST_FRAC_Z;
      end
      ST_FRAC_Z: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bgi_pkg::MUL_FRAC_Z;
        cmd.rd_en   = 1'b1;
        cmd.rd_col  = 1'b0;
        state_next  = ST_FRAC_M;
      end
      ST_FRAC_M: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = bgi_pkg::MUL_FRAC_M;
        cmd.rd_en    = 1'b1;
        cmd.rd_col   = 1'b1;
        cmd.cap_fz   = 1'b1;
        cmd.lat_col0 = 1'b1;
        state_next   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.load_diff = 1'b1;
        if (blend == bgi_pkg::BLEND_COL0) begin
          cmd.cap_fm   = 1'b1;
          cmd.lat_col1 = 1'b1;
        end
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bgi_pkg::MUL_LO;
        state_next  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = bgi_pkg::MUL_HI;
        cmd.acc_init = 1'b1;
        state_next   = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.fin_en = 1'b1;
        case (blend)
          bgi_pkg::BLEND_COL0: begin
            blend_next = bgi_pkg::BLEND_COL1;
            state_next = ST_DIFF;
          end
          bgi_pkg::BLEND_COL1: begin
            blend_next = bgi_pkg::BLEND_MASS;
            state_next = ST_DIFF;
          end
          default: begin
            state_next = ST_OUTPUT;
          end
        endcase
      end
      ST_OUTPUT: begin
        // The output register may still hold the previous result.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      blend     <= bgi_pkg::BLEND_COL0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      blend     <= blend_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/core/bgi_datapath.sv -----
// ----------------------------------------------------------------------------
// bgi_datapath: storage and arithmetic of the bilinear grid interpolator
// Yield table with one write and two registered read ports, breakpoint
// search, one shared signed multiplier, accumulator and saturating output.
// ----------------------------------------------------------------------------
module bgi_datapath (
  input  logic                               clk,
  input  bgi_pkg::cmd_t                      cmd,
  input  logic [bgi_pkg::COORD_W-1:0]        star_mass,
  input  logic [bgi_pkg::COORD_W-1:0]        metallicity,
  input  logic [bgi_pkg::ROW_W-1:0]          row_index,
  input  logic [bgi_pkg::COL_W-1:0]          column_index,
  input  logic signed [bgi_pkg::VALUE_W-1:0] entry_value,
  output logic signed [bgi_pkg::VALUE_W-1:0] interpolated_value,
  output logic                               saturated
);

  localparam logic signed [bgi_pkg::RES_W-1:0] RES_MAX =
    {{(bgi_pkg::RES_W-bgi_pkg::VALUE_W+1){1'b0}}, {(bgi_pkg::VALUE_W-1){1'b1}}};
  localparam logic signed [bgi_pkg::RES_W-1:0] RES_MIN =
    {{(bgi_pkg::RES_W-bgi_pkg::VALUE_W+1){1'b1}}, {(bgi_pkg::VALUE_W-1){1'b0}}};

  logic [bgi_pkg::COORD_W-1:0]        mass_q, metal_q;
  logic [bgi_pkg::COL_W-1:0]          i_q, i_lo, i_scan, rd_col;
  logic [bgi_pkg::ROW_W-1:0]          j_q, j_lo, j_scan;
  logic [bgi_pkg::COORD_W-1:0]        dm, dz;
  logic [bgi_pkg::TBL_AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
  logic signed [bgi_pkg::VALUE_W-1:0] tbl [bgi_pkg::TBL_DEPTH];
  logic signed [bgi_pkg::VALUE_W-1:0] rd_a, rd_b;
  logic signed [bgi_pkg::VALUE_W-1:0] c00, c10, c01, c11;
  logic [bgi_pkg::FZ_W-1:0]           fz, f_sel;
  logic [bgi_pkg::FM_W-1:0]           fm;
  logic signed [bgi_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [bgi_pkg::PROD_W-1:0]  prod_q;
  logic signed [bgi_pkg::DIFF_W-1:0]  diff_q, diff_next;
  logic signed [bgi_pkg::T_W-1:0]     t0, t1;
  logic signed [bgi_pkg::ACC_W-1:0]   acc;
  logic signed [bgi_pkg::RES_W-1:0]   lo_sel, fin_sum, res_q;
  logic                               wr_ok;

  // First breakpoint at or above each coordinate. The grids are sorted, so
  // counting the breakpoints below the coordinate gives the same index.
  always_comb begin
    i_scan = '0;
    for (int k = 0; k < bgi_pkg::MASS_POINTS - 1; k++) begin
      if (bgi_pkg::MASS_BP[k] < mass_q) begin
        i_scan = bgi_pkg::COL_W'(k + 1);
      end
    end
  end

  always_comb begin
    j_scan = '0;
    for (int k = 0; k < bgi_pkg::METAL_POINTS - 1; k++) begin
      if (bgi_pkg::METAL_BP[k] < metal_q) begin
        j_scan = bgi_pkg::ROW_W'(k + 1);
      end
    end
  end

  assign i_lo = (i_q == '0) ? '0 : i_q - 1'b1;
  assign j_lo = (j_q == '0) ? '0 : j_q - 1'b1;

  // Offsets into the selected interval; zero on the clamped edge.
  always_comb begin
    dm = '0;
    if ((i_q != '0) && (mass_q > bgi_pkg::MASS_BP[i_lo])) begin
      dm = mass_q - bgi_pkg::MASS_BP[i_lo];
    end
    dz = '0;
    if ((j_q != '0) && (metal_q > bgi_pkg::METAL_BP[j_lo])) begin
      dz = metal_q - bgi_pkg::METAL_BP[j_lo];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_query) begin
      mass_q  <= star_mass;
      metal_q <= metallicity;
    end
    if (cmd.load_index) begin
      i_q <= i_scan;
      j_q <= j_scan;
    end
  end

  // Yield table.
  assign wr_ok     = (int'(row_index) < bgi_pkg::METAL_POINTS) &&
                     (int'(column_index) < bgi_pkg::MASS_POINTS);
  assign wr_addr   = bgi_pkg::tbl_addr(row_index, column_index);
  assign rd_col    = cmd.rd_col ? i_q : i_lo;
  assign rd_addr_a = bgi_pkg::tbl_addr(j_lo, rd_col);
  assign rd_addr_b = bgi_pkg::tbl_addr(j_q, rd_col);

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && wr_ok) begin
      tbl[wr_addr] <= entry_value;
    end
    if (cmd.rd_en) begin
      rd_a <= tbl[rd_addr_a];
      rd_b <= tbl[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_col0) begin
      c00 <= rd_a;
      c10 <= rd_b;
    end
    if (cmd.lat_col1) begin
      c01 <= rd_a;
      c11 <= rd_b;
    end
  end

  // Shared multiplier. A blend difference is split into a low unsigned part
  // and a high signed part, multiplied in consecutive cycles.
  assign f_sel = (cmd.blend_sel == bgi_pkg::BLEND_MASS) ? bgi_pkg::FZ_W'(fm) : fz;

  always_comb begin
    case (cmd.mul_sel)
      bgi_pkg::MUL_FRAC_Z: begin
        mul_a = bgi_pkg::MUL_W'(dz);
        mul_b = bgi_pkg::MUL_W'(bgi_pkg::METAL_RECIP[j_q]);
      end
      bgi_pkg::MUL_FRAC_M: begin
        mul_a = bgi_pkg::MUL_W'(dm);
        mul_b = bgi_pkg::MUL_W'(bgi_pkg::MASS_RECIP[i_q]);
      end
      bgi_pkg::MUL_LO: begin
        mul_a = bgi_pkg::MUL_W'(f_sel);
        mul_b = bgi_pkg::MUL_W'(diff_q[bgi_pkg::SPLIT-1:0]);
      end
      bgi_pkg::MUL_HI: begin
        mul_a = bgi_pkg::MUL_W'(f_sel);
        mul_b = bgi_pkg::MUL_W'(diff_q >>> bgi_pkg::SPLIT);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd.cap_fz) begin
      fz <= prod_q[bgi_pkg::FRAC_LSB +: bgi_pkg::FZ_W];
    end
    if (cmd.cap_fm) begin
      fm <= prod_q[bgi_pkg::FRAC_LSB +: bgi_pkg::FM_W];
    end
  end

  // Blend operands: upper minus lower endpoint, and the lower endpoint.
  always_comb begin
    case (cmd.blend_sel)
      bgi_pkg::BLEND_COL0: begin
        diff_next = bgi_pkg::DIFF_W'(c10) - bgi_pkg::DIFF_W'(c00);
        lo_sel    = bgi_pkg::RES_W'(c00);
      end
      bgi_pkg::BLEND_COL1: begin
        diff_next = bgi_pkg::DIFF_W'(c11) - bgi_pkg::DIFF_W'(c01);
        lo_sel    = bgi_pkg::RES_W'(c01);
      end
      bgi_pkg::BLEND_MASS: begin
        diff_next = bgi_pkg::DIFF_W'(t1) - bgi_pkg::DIFF_W'(t0);
        lo_sel    = bgi_pkg::RES_W'(t0);
      end
      default: begin
        diff_next = '0;
        lo_sel    = '0;
      end
    endcase
  end

  // Dropping the low bits of the biased sum rounds to nearest, halves up.
  assign fin_sum = lo_sel + signed'(acc[bgi_pkg::ACC_W-1:bgi_pkg::FRAC_LSB]);

  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      diff_q <= diff_next;
    end
    if (cmd.acc_init) begin
      acc <= bgi_pkg::ACC_W'(prod_q) + bgi_pkg::ACC_W'(bgi_pkg::ROUND_HALF);
    end else if (cmd.acc_add) begin
      acc <= acc + (bgi_pkg::ACC_W'(prod_q) <<< bgi_pkg::SPLIT);
    end
    if (cmd.fin_en) begin
      case (cmd.blend_sel)
        bgi_pkg::BLEND_COL0: t0 <= fin_sum[bgi_pkg::T_W-1:0];
        bgi_pkg::BLEND_COL1: t1 <= fin_sum[bgi_pkg::T_W-1:0];
        default:             res_q <= fin_sum;
      endcase
    end
  end

  // Saturating result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (res_q > RES_MAX) begin
        interpolated_value <= RES_MAX[bgi_pkg::VALUE_W-1:0];
        saturated          <= 1'b1;
      end else if (res_q < RES_MIN) begin
        interpolated_value <= RES_MIN[bgi_pkg::VALUE_W-1:0];
        saturated          <= 1'b1;
      end else begin
        interpolated_value <= res_q[bgi_pkg::VALUE_W-1:0];
        saturated          <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/bgi_checker.sv -----
// ----------------------------------------------------------------------------
// bgi_checker: port-level checks of the bilinear grid interpolator
// Watches both channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module bgi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               req_opcode,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [bgi_pkg::VALUE_W-1:0] rsp_value,
  input logic                               rsp_saturated
);

  logic query_beat, write_beat;

  assign query_beat = req_valid && req_ready && (req_opcode == bgi_pkg::OP_QUERY);
  assign write_beat = req_valid && req_ready && (req_opcode == bgi_pkg::OP_WRITE);

  // A held result beat does not change.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_saturated))
    else $error("result beat changed while stalled");

  // A fresh result follows a query by the fixed latency.
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(query_beat, bgi_pkg::RESULT_DELAY))
    else $error("result appeared without a matching query");

  // A query occupies the block; a write does not.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_beat |=> !req_ready)
    else $error("request taken while a query is in progress");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    write_beat |=> req_ready)
    else $error("table write stalled the request channel");

  // A clipped result sits exactly on a range limit.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_saturated |->
      (rsp_value == 32'sh7FFF_FFFF) || (rsp_value == 32'sh8000_0000))
    else $error("saturated result is not a range limit");

endmodule

bind bilinear_grid_interpolator_top bgi_checker u_bgi_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_opcode    (req.opcode),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_value     (rsp.interpolated_value),
  .rsp_saturated (rsp.saturated)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bilinear grid interpolator
// Loads the whole yield table, then drives corner queries, a long random mix
// of writes and queries, a stretch of output back-pressure and a streaming
// burst. A predictor inside the bench works out every interpolated value
// from its own copy of the table, and a checker compares each result beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The longest quiet spell of a correct run is the sink hold-off below plus
  // one query's run through the sequencer and a sender gap. The watchdog
  // allows several times that before it calls the run hung.
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT      = 2000;

  // One request beat as the bench sees it.
  typedef struct packed {
    bgi_pkg::opcode_t                   op;
    bgi_pkg::coord_t                    mass;
    bgi_pkg::coord_t                    metal;
    logic [bgi_pkg::ROW_W-1:0]          row;
    logic [bgi_pkg::COL_W-1:0]          col;
    logic signed [bgi_pkg::VALUE_W-1:0] value;
  } grid_req_t;

  // One predicted result beat.
  typedef struct packed {
    logic signed [bgi_pkg::VALUE_W-1:0] value;
    logic                               sat;
  } yield_rsp_t;

  // Ways in which the result sink withholds ready.
  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_pattern_t;

  logic clk;
  logic rst;

  bgi_req_if req ();
  bgi_rsp_if rsp ();

  bilinear_grid_interpolator_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Breakpoints of the two axes: mass in Q4.12, metallicity in Q0.16. The
  // mass grid repeats one point, which gives an empty interval that the
  // search can never land in.
  int unsigned mass_knots [bgi_pkg::MASS_POINTS] = '{
    3686, 4096, 5325, 5325, 6144, 6963, 8192, 10240, 12288, 16384, 20480,
    28672, 32768};
  int unsigned metal_knots [bgi_pkg::METAL_POINTS] = '{66, 262, 524, 1311, 2621};

  // The bench's copy of the yield table and the queue of values it expects.
  int         yield_grid [bgi_pkg::METAL_POINTS][bgi_pkg::MASS_POINTS];
  yield_rsp_t expected_yields [$];

  // Knobs that the test tasks turn.
  bit gaps_on;
  bit sink_stalls;
  int hold_off_request;
  int burst_left;

  // Run statistics.
  int writes_taken;
  int writes_dropped;
  int queries_taken;
  int results_checked;
  int saturations_seen;
  int errors;

  yield_rsp_t want;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Position of x inside the interval lo..hi as an unsigned Q16 fraction.
  // The interval width is replaced by a rounded reciprocal of 2^32 / width,
  // and the product is truncated. Past the upper end the fraction exceeds
  // one, which is how extrapolation happens; an empty interval gives zero.
  function automatic longint unsigned knot_fraction(input int unsigned x,
                                                    input int unsigned lo,
                                                    input int unsigned hi);
    longint unsigned span;
    longint unsigned recip;
    longint unsigned offset;
    if (hi <= lo) return 0;
    span   = hi - lo;
    recip  = ((64'd1 << 32) + span / 2) / span;
    offset = (x > lo) ? longint'(x - lo) : 0;
    return (offset * recip) >> 16;
  endfunction

  // lo + frac * (hi - lo), with the Q16 product rounded to nearest and
  // halves going up. Everything stays 64 bits wide, so nothing wraps.
  function automatic longint lerp_q16(input longint frac, input longint lo,
                                      input longint hi);
    return lo + ((frac * (hi - lo) + 64'sd32768) >>> 16);
  endfunction

  // Value of one table column after the metallicity blend. Row index zero
  // means the metallicity sits at or below the first point: no blend.
  function automatic longint metal_blend(input int j, input longint fz,
                                         input int col);
    if (j == 0) return longint'(yield_grid[0][col]);
    return lerp_q16(fz, yield_grid[j-1][col], yield_grid[j][col]);
  endfunction

  // Works out the result of one query and queues it.
  function automatic void predict_query(input bgi_pkg::coord_t mass,
                                        input bgi_pkg::coord_t metal);
    int         i;
    int         j;
    longint     fz;
    longint     acc;
    yield_rsp_t r;
    i  = 0;
    j  = 0;
    fz = 0;
    // First breakpoint at or above each coordinate, never past the last one.
    while (i < bgi_pkg::MASS_POINTS - 1 && mass_knots[i] < mass) i++;
    while (j < bgi_pkg::METAL_POINTS - 1 && metal_knots[j] < metal) j++;
    if (j > 0) fz = knot_fraction(metal, metal_knots[j-1], metal_knots[j]);
    if (i == 0) begin
      acc = metal_blend(j, fz, 0);
    end else begin
      acc = lerp_q16(knot_fraction(mass, mass_knots[i-1], mass_knots[i]),
                     metal_blend(j, fz, i - 1), metal_blend(j, fz, i));
    end
    if (acc > 64'sd2147483647) begin
      r.value = 32'h7FFF_FFFF;
      r.sat   = 1'b1;
    end else if (acc < -64'sd2147483648) begin
      r.value = 32'h8000_0000;
      r.sat   = 1'b1;
    end else begin
      r.value = acc[31:0];
      r.sat   = 1'b0;
    end
    expected_yields.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Beat construction
  // --------------------------------------------------------------------------

  // A write beat; the query fields carry noise that the block must ignore.
  function automatic grid_req_t write_beat(input int row, input int col,
                                           input logic signed [bgi_pkg::VALUE_W-1:0] value);
    grid_req_t b;
    b.op    = bgi_pkg::OP_WRITE;
    b.mass  = bgi_pkg::COORD_W'($urandom);
    b.metal = bgi_pkg::COORD_W'($urandom);
    b.row   = bgi_pkg::ROW_W'(row);
    b.col   = bgi_pkg::COL_W'(col);
    b.value = value;
    return b;
  endfunction

  // A query beat; the write fields carry noise.
  function automatic grid_req_t query_beat(input bgi_pkg::coord_t mass,
                                           input bgi_pkg::coord_t metal);
    grid_req_t b;
    b.op    = bgi_pkg::OP_QUERY;
    b.mass  = mass;
    b.metal = metal;
    b.row   = bgi_pkg::ROW_W'($urandom);
    b.col   = bgi_pkg::COL_W'($urandom);
    b.value = bgi_pkg::VALUE_W'($urandom);
    return b;
  endfunction

  // Table values: mostly the whole signed range, some small ones so that
  // extrapolation stays in range, and now and then an extreme.
  function automatic logic signed [bgi_pkg::VALUE_W-1:0] random_entry_value();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2:    return bgi_pkg::VALUE_W'(int'($urandom_range(0, 2097151)) - 1048576);
      default: return bgi_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  // A coordinate on one axis: mostly inside the grid (with a margin below
  // the first point), some right next to a breakpoint, some anywhere in the
  // 16-bit field, which mostly means extrapolation.
  function automatic bgi_pkg::coord_t random_coord(input bit mass_axis);
    int unsigned knot;
    knot = mass_axis ? mass_knots[$urandom_range(0, bgi_pkg::MASS_POINTS - 1)]
                     : metal_knots[$urandom_range(0, bgi_pkg::METAL_POINTS - 1)];
    case ($urandom_range(0, 9))
      0, 1:    return bgi_pkg::COORD_W'($urandom);
      2, 3:    return bgi_pkg::COORD_W'(knot + $urandom_range(0, 2) - 1);
      default: return mass_axis ? bgi_pkg::COORD_W'($urandom_range(3000, 34000))
                                : bgi_pkg::COORD_W'($urandom_range(0, 3000));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------

  // Offers one beat and returns at the edge that takes it. The sender runs in
  // bursts of random length when gaps are on; between bursts valid may drop.
  // Once the beat is taken, the bench's table copy is updated or the query
  // result predicted, in the same order as the block sees the beats.
  task automatic send_beat(input grid_req_t b);
    int idle;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      idle       = $urandom_range(0, 4);
      if (idle != 0) begin
        req.valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    req.valid        <= 1'b1;
    req.opcode       <= b.op;
    req.star_mass    <= b.mass;
    req.metallicity  <= b.metal;
    req.row_index    <= b.row;
    req.column_index <= b.col;
    req.entry_value  <= b.value;
    do @(posedge clk); while (!req.ready);
    if (b.op == bgi_pkg::OP_WRITE) begin
      // Beats that address a row or column outside the grid are dropped.
      if (b.row < bgi_pkg::METAL_POINTS && b.col < bgi_pkg::MASS_POINTS) begin
        yield_grid[b.row][b.col] = b.value;
        writes_taken++;
      end else begin
        writes_dropped++;
      end
    end else begin
      queries_taken++;
      predict_query(b.mass, b.metal);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every entry is written before the first query, so no query can ever read
  // an entry whose contents are still undefined.
  task automatic test_table_load();
    gaps_on     = 1'b1;
    sink_stalls = 1'b1;
    for (int r = 0; r < bgi_pkg::METAL_POINTS; r++)
      for (int c = 0; c < bgi_pkg::MASS_POINTS; c++)
        send_beat(write_beat(r, c, random_entry_value()));
  endtask

  // Hand-picked queries: field extremes, exact breakpoints and their
  // neighbors, clamping, extrapolation, clipping both ways and dropped
  // writes.
  task automatic test_corner_queries();
    gaps_on     = 1'b1;
    sink_stalls = 1'b1;
    // Extreme entries in the clamped corner, read straight back.
    send_beat(write_beat(0, 0, 32'h7FFF_FFFF));
    send_beat(query_beat(16'd0, 16'd0));
    send_beat(write_beat(0, 0, 32'h8000_0000));
    send_beat(query_beat(16'd0, 16'd0));
    // Both coordinates at the top of their fields.
    send_beat(query_beat(16'hFFFF, 16'hFFFF));
    // On the first breakpoints, and one step above them.
    send_beat(query_beat(16'd3686, 16'd66));
    send_beat(query_beat(16'd3687, 16'd67));
    // On the repeated mass point and one above it: the search has to jump
    // over the empty interval into the next real one.
    send_beat(query_beat(16'd5325, 16'd524));
    send_beat(query_beat(16'd5326, 16'd1311));
    // On the last breakpoints, then just past them.
    send_beat(query_beat(16'd32768, 16'd2621));
    send_beat(query_beat(16'd32769, 16'd2622));
    // Metallicity extrapolation between opposite extremes clips high, then
    // low with the extremes swapped. The mass lands exactly on the last
    // point, so the top column is used unchanged.
    send_beat(write_beat(3, 12, 32'h8000_0000));
    send_beat(write_beat(4, 12, 32'h7FFF_FFFF));
    send_beat(query_beat(16'd32768, 16'hFFFF));
    send_beat(write_beat(3, 12, 32'h7FFF_FFFF));
    send_beat(write_beat(4, 12, 32'h8000_0000));
    send_beat(query_beat(16'd32768, 16'hFFFF));
    // Writes outside the grid must leave the table alone. A block that
    // folded column 13 of row 0 into row 1 would change the query below,
    // which reads column 0 of rows 0 and 1.
    send_beat(write_beat(5, 0, random_entry_value()));
    send_beat(write_beat(7, 15, random_entry_value()));
    send_beat(write_beat(0, 13, random_entry_value()));
    send_beat(write_beat(4, 15, random_entry_value()));
    send_beat(query_beat(16'd0, 16'd200));
    // Mass extrapolation along the lowest metallicity row.
    send_beat(query_beat(16'd40000, 16'd0));
  endtask

  // The bulk of the run: mostly queries, the rest writes that keep the table
  // moving, with a few that address cells outside the grid.
  task automatic test_random_traffic();
    gaps_on     = 1'b1;
    sink_stalls = 1'b1;
    repeat (700) begin
      if ($urandom_range(0, 3) != 0)
        send_beat(query_beat(random_coord(1'b1), random_coord(1'b0)));
      else if ($urandom_range(0, 15) == 0)
        send_beat(write_beat($urandom_range(0, 7), $urandom_range(0, 15),
                             random_entry_value()));
      else
        send_beat(write_beat($urandom_range(0, bgi_pkg::METAL_POINTS - 1),
                             $urandom_range(0, bgi_pkg::MASS_POINTS - 1),
                             random_entry_value()));
    end
  endtask

  // The sink holds ready low for a long stretch while queries keep coming
  // with no gaps. One result parks in the output register, the next query
  // finishes and waits behind it, and then the request side has to stall.
  task automatic test_output_backpressure();
    gaps_on          = 1'b0;
    sink_stalls      = 1'b0;
    hold_off_request = SINK_HOLD_CYCLES;
    repeat (12) send_beat(query_beat(random_coord(1'b1), random_coord(1'b0)));
  endtask

  // Back-to-back beats with an always-ready sink: the block runs at its own
  // pace, and writes stream in between the queries.
  task automatic test_streaming();
    gaps_on     = 1'b0;
    sink_stalls = 1'b0;
    repeat (60) begin
      if ($urandom_range(0, 2) == 0)
        send_beat(write_beat($urandom_range(0, bgi_pkg::METAL_POINTS - 1),
                             $urandom_range(0, bgi_pkg::MASS_POINTS - 1),
                             random_entry_value()));
      else
        send_beat(query_beat(random_coord(1'b1), random_coord(1'b0)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, result sink, checker and watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result sink. Outside a requested hold-off it either keeps ready high
  // or, while stalls are enabled, switches at random intervals between
  // always ready, a coin toss, rare ready and a fixed period.
  initial begin : result_sink
    int            hold_left;
    int            pattern_left;
    int            phase;
    sink_pattern_t pattern;
    hold_left    = 0;
    pattern_left = 0;
    phase        = 0;
    pattern      = SINK_OPEN;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 5;
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (!sink_stalls) begin
        rsp.ready <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern      = sink_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pattern)
          SINK_OPEN:   rsp.ready <= 1'b1;
          SINK_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
          default:     rsp.ready <= (phase < 2);
        endcase
      end
    end
  end

  // Each result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_yields.size() == 0) begin
        $display("%0t: result with no query pending: interpolated_value %0d, saturated %0b",
                 $time, rsp.interpolated_value, rsp.saturated);
        errors++;
      end else begin
        want = expected_yields.pop_front();
        results_checked++;
        if (rsp.saturated === 1'b1) saturations_seen++;
        if (rsp.interpolated_value !== want.value) begin
          $display("%0t: interpolated_value mismatch: expected %0d, actual %0d",
                   $time, want.value, rsp.interpolated_value);
          errors++;
        end
        if (rsp.saturated !== want.sat) begin
          $display("%0t: saturated mismatch: expected %0b, actual %0b",
                   $time, want.sat, rsp.saturated);
          errors++;
        end
      end
    end
  end

  // Ends the run when no beat has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
             $time, quiet, expected_yields.size());
    $display("testbench: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------

  initial begin
    gaps_on          = 1'b1;
    sink_stalls      = 1'b1;
    hold_off_request = 0;
    burst_left       = 0;
    writes_taken     = 0;
    writes_dropped   = 0;
    queries_taken    = 0;
    results_checked  = 0;
    saturations_seen = 0;
    errors           = 0;

    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.opcode       <= bgi_pkg::OP_WRITE;
    req.star_mass    <= '0;
    req.metallicity  <= '0;
    req.row_index    <= '0;
    req.column_index <= '0;
    req.entry_value  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_table_load();
    test_corner_queries();
    test_random_traffic();
    test_output_backpressure();
    test_streaming();
    req.valid <= 1'b0;

    // Drain the outstanding results, then leave room for any stray beat.
    while (expected_yields.size() != 0) @(posedge clk);
    repeat (bgi_pkg::RESULT_DELAY + 5) @(posedge clk);

    $display("Covered %0d table writes, %0d dropped writes and %0d queries.",
             writes_taken, writes_dropped, queries_taken);
    $display("Checked %0d results (%0d clipped), %0d mismatches.",
             results_checked, saturations_seen, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
